@@ rtl/core/face_view_angle_cosine_unit_defines.svh @@
// Assertion macros used by the checker of the view-angle cosine unit.
`ifndef FACE_VIEW_ANGLE_COSINE_UNIT_DEFINES_SVH
`define FACE_VIEW_ANGLE_COSINE_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FVAC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define FVAC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define FVAC_ASSERT_RST(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/fvac_pkg.sv @@
`timescale 1ns / 1ps
package fvac_pkg;

  localparam int CoordW    = 16;
  localparam int CoefW     = 16;
  localparam int FracShift = 12;
  localparam int ProdW     = CoordW + CoefW;
  localparam int AccW      = ProdW + 2;
  localparam int PW        = AccW - FracShift;
  localparam int EW        = PW + 1;
  localparam int XW        = 2 * EW;
  localparam int NW        = XW + 1;
  localparam int ShW       = $clog2(NW);
  localparam int NormTop   = 14;
  localparam int SvW       = 16;
  localparam int SqW       = 2 * SvW;
  localparam int DotW      = SqW + 2;
  localparam int MagW      = DotW - 1;
  localparam int RootW     = 24;
  localparam int RadShift  = 16;
  localparam int RadW      = 2 * RootW;
  localparam int DenW      = 2 * RootW;
  localparam int NumShift  = 30;
  localparam int NumW      = 64;
  localparam int QW        = 15;
  localparam int CosW      = 16;
  localparam logic [CosW-1:0] CosOne = 16'd16384;

  localparam int DataW     = 64;
  localparam int AddrW     = 5;
  localparam int ByteSelW  = 3;
  localparam int ThrW      = 16;

  typedef enum logic [AddrW-ByteSelW-1:0] {
    REG_ROW_X  = 2'd0,
    REG_ROW_Y  = 2'd1,
    REG_ROW_Z  = 2'd2,
    REG_THRESH = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][DataW-1:0] row;
    logic signed [ThrW-1:0] thr;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

@@ rtl/core/fvac_if.sv @@
`timescale 1ns / 1ps
interface fvac_in_if;
  logic valid;
  logic ready;
  logic signed [fvac_pkg::CoordW-1:0] a_x;
  logic signed [fvac_pkg::CoordW-1:0] a_y;
  logic signed [fvac_pkg::CoordW-1:0] a_z;
  logic signed [fvac_pkg::CoordW-1:0] b_x;
  logic signed [fvac_pkg::CoordW-1:0] b_y;
  logic signed [fvac_pkg::CoordW-1:0] b_z;
  logic signed [fvac_pkg::CoordW-1:0] c_x;
  logic signed [fvac_pkg::CoordW-1:0] c_y;
  logic signed [fvac_pkg::CoordW-1:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface fvac_out_if;
  logic valid;
  logic ready;
  logic signed [fvac_pkg::CosW-1:0] cosine;
  logic below_threshold;
  logic degenerate;

  modport source (output valid, cosine, below_threshold, degenerate, input ready);
  modport sink (input valid, cosine, below_threshold, degenerate, output ready);
endinterface

@@ rtl/core/fvac_regs.sv @@
`timescale 1ns / 1ps
module fvac_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fvac_pkg::AddrW-1:0]   paddr,
  input  logic [fvac_pkg::DataW-1:0]   pwdata,
  output logic [fvac_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output fvac_pkg::cfg_t               cfg
);
  localparam int AddrW    = fvac_pkg::AddrW;
  localparam int ByteSelW = fvac_pkg::ByteSelW;
  localparam int DataW    = fvac_pkg::DataW;
  localparam int ThrW     = fvac_pkg::ThrW;

  fvac_pkg::cfg_t   cfg_r, cfg_nxt;
  fvac_pkg::reg_idx_t idx;
  logic             wr;

  assign idx    = fvac_pkg::reg_idx_t'(paddr[AddrW-1:ByteSelW]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        fvac_pkg::REG_ROW_X:  cfg_nxt.row[0] = pwdata;
        fvac_pkg::REG_ROW_Y:  cfg_nxt.row[1] = pwdata;
        fvac_pkg::REG_ROW_Z:  cfg_nxt.row[2] = pwdata;
        fvac_pkg::REG_THRESH: cfg_nxt.thr    = pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fvac_pkg::REG_ROW_X:  prdata = cfg_r.row[0];
      fvac_pkg::REG_ROW_Y:  prdata = cfg_r.row[1];
      fvac_pkg::REG_ROW_Z:  prdata = cfg_r.row[2];
      fvac_pkg::REG_THRESH: prdata = {{(DataW-ThrW){1'b0}}, cfg_r.thr};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end
endmodule

@@ rtl/core/fvac_xform.sv @@
`timescale 1ns / 1ps
module fvac_xform (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        en,
  input  logic                                        in_valid,
  input  logic [2:0][2:0][fvac_pkg::CoordW-1:0]       vtx,
  input  fvac_pkg::cfg_t                              cfg,
  output fvac_pkg::ctl_t                              ctl_o,
  output logic [2:0][fvac_pkg::EW-1:0]                e1_o,
  output logic [2:0][fvac_pkg::EW-1:0]                e2_o,
  output logic [2:0][fvac_pkg::EW-1:0]                c_o
);
  localparam int CoefW = fvac_pkg::CoefW;
  localparam int ProdW = fvac_pkg::ProdW;
  localparam int AccW  = fvac_pkg::AccW;
  localparam int PW    = fvac_pkg::PW;
  localparam int EW    = fvac_pkg::EW;
  localparam int FracShift = fvac_pkg::FracShift;

  // prod[vertex][row][column]
  logic [2:0][2:0][2:0][ProdW-1:0] prod_r, prod_nxt;
  logic [2:0][2:0][PW-1:0]         pt_r, pt_nxt;
  logic [2:0][EW-1:0]              e1_r, e1_nxt, e2_r, e2_nxt, c_r, c_nxt;
  logic [2:0]                      v_r, v_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          prod_nxt[i][j][k] = ProdW'($signed(cfg.row[j][k*CoefW +: CoefW]) *
                                     $signed(vtx[i][k]));
        end
      end
    end
  end

  // Sum the row, add translation, floor-divide by the coefficient scale.
  always_comb begin
    logic signed [AccW-1:0] acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = AccW'($signed(prod_r[i][j][0])) + AccW'($signed(prod_r[i][j][1])) +
              AccW'($signed(prod_r[i][j][2])) +
              (AccW'($signed(cfg.row[j][3*CoefW +: CoefW])) <<< FracShift);
        pt_nxt[i][j] = acc[FracShift +: PW];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e1_nxt[j] = EW'($signed(pt_r[1][j])) - EW'($signed(pt_r[0][j]));
      e2_nxt[j] = EW'($signed(pt_r[2][j])) - EW'($signed(pt_r[0][j]));
      c_nxt[j]  = EW'($signed(pt_r[0][j])) + EW'($signed(pt_r[1][j])) +
                  EW'($signed(pt_r[2][j]));
    end
  end

  assign v_nxt = {v_r[1:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pt_r   <= pt_nxt;
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      c_r    <= c_nxt;
    end
  end

  assign ctl_o.valid = v_r[2];
  assign ctl_o.degen = 1'b0;
  assign e1_o = e1_r;
  assign e2_o = e2_r;
  assign c_o  = c_r;
endmodule

@@ rtl/core/fvac_norm.sv @@
`timescale 1ns / 1ps
module fvac_norm (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  fvac_pkg::ctl_t                       ctl_i,
  input  logic [2:0][fvac_pkg::EW-1:0]         e1_i,
  input  logic [2:0][fvac_pkg::EW-1:0]         e2_i,
  input  logic [2:0][fvac_pkg::EW-1:0]         c_i,
  output fvac_pkg::ctl_t                       ctl_o,
  output logic signed [fvac_pkg::DotW-1:0]     dot_o,
  output logic [fvac_pkg::SqW-1:0]             nn_o,
  output logic [fvac_pkg::SqW-1:0]             cc_o
);
  localparam int EW      = fvac_pkg::EW;
  localparam int XW      = fvac_pkg::XW;
  localparam int NW      = fvac_pkg::NW;
  localparam int ShW     = fvac_pkg::ShW;
  localparam int SvW     = fvac_pkg::SvW;
  localparam int SqW     = fvac_pkg::SqW;
  localparam int DotW    = fvac_pkg::DotW;
  localparam int NormTop = fvac_pkg::NormTop;
  localparam int NStg    = 7;
  localparam int DegStg  = 2;

  fvac_pkg::ctl_t ctl_r [NStg];
  fvac_pkg::ctl_t ctl_nxt [NStg];

  logic signed [XW-1:0]  xp_r [6];
  logic signed [XW-1:0]  xp_nxt [6];
  logic [2:0][EW-1:0]    c4_r, c5_r;
  logic signed [NW-1:0]  n_r [3];
  logic signed [NW-1:0]  n_nxt [3];
  // vector 0 is the normal, vector 1 the centroid sum
  logic [NW-1:0]         mag_r [2][3];
  logic [NW-1:0]         mag_nxt [2][3];
  logic [NW-1:0]         mag7_r [2][3];
  logic [1:0][2:0]       sgn_r, sgn_nxt, sgn7_r;
  logic [1:0]            right_r, right_nxt;
  logic [ShW-1:0]        amt_r [2];
  logic [ShW-1:0]        amt_nxt [2];
  logic signed [SvW-1:0] sv_r [2][3];
  logic signed [SvW-1:0] sv_nxt [2][3];
  logic signed [SqW-1:0] dp_r [3];
  logic signed [SqW-1:0] dp_nxt [3];
  logic signed [SqW-1:0] sq_r [2][3];
  logic signed [SqW-1:0] sq_nxt [2][3];
  logic signed [DotW-1:0] dot_r, dot_nxt;
  logic [SqW-1:0]        nn_r, nn_nxt, cc_r, cc_nxt;
  logic                  degen;

  // Cross product terms.
  always_comb begin
    xp_nxt[0] = $signed(e1_i[1]) * $signed(e2_i[2]);
    xp_nxt[1] = $signed(e1_i[2]) * $signed(e2_i[1]);
    xp_nxt[2] = $signed(e1_i[2]) * $signed(e2_i[0]);
    xp_nxt[3] = $signed(e1_i[0]) * $signed(e2_i[2]);
    xp_nxt[4] = $signed(e1_i[0]) * $signed(e2_i[1]);
    xp_nxt[5] = $signed(e1_i[1]) * $signed(e2_i[0]);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n_nxt[j] = NW'(xp_r[2*j]) - NW'(xp_r[2*j+1]);
    end
  end

  // Split into sign and magnitude; flag a zero vector.
  always_comb begin
    logic signed [NW-1:0] cx;
    for (int j = 0; j < 3; j++) begin
      cx = NW'($signed(c5_r[j]));
      sgn_nxt[0][j] = n_r[j][NW-1];
      sgn_nxt[1][j] = cx[NW-1];
      mag_nxt[0][j] = n_r[j][NW-1] ? NW'(-n_r[j]) : NW'(n_r[j]);
      mag_nxt[1][j] = cx[NW-1] ? NW'(-cx) : NW'(cx);
    end
    degen = ((n_r[0] == '0) && (n_r[1] == '0) && (n_r[2] == '0)) ||
            ((c5_r[0] == '0) && (c5_r[1] == '0) && (c5_r[2] == '0));
  end

  // Locate the leading one of the largest component.
  always_comb begin
    logic [NW-1:0]  orv;
    logic [ShW-1:0] pos;
    for (int v = 0; v < 2; v++) begin
      orv = mag_r[v][0] | mag_r[v][1] | mag_r[v][2];
      pos = '0;
      for (int b = 0; b < NW; b++) begin
        if (orv[b]) pos = ShW'(b);
      end
      right_nxt[v] = (pos > ShW'(NormTop));
      amt_nxt[v]   = (pos > ShW'(NormTop)) ? pos - ShW'(NormTop) : ShW'(NormTop) - pos;
    end
  end

  // Bring the leading one to bit NormTop, truncating toward zero.
  always_comb begin
    logic [NW-1:0]    mv;
    logic [SvW-1:0]   mx;
    for (int v = 0; v < 2; v++) begin
      for (int j = 0; j < 3; j++) begin
        mv = right_r[v] ? (mag7_r[v][j] >> amt_r[v]) : (mag7_r[v][j] << amt_r[v]);
        mx = {1'b0, mv[SvW-2:0]};
        sv_nxt[v][j] = sgn7_r[v][j] ? $signed(~mx + 1'b1) : $signed(mx);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dp_nxt[j]    = sv_r[0][j] * sv_r[1][j];
      sq_nxt[0][j] = sv_r[0][j] * sv_r[0][j];
      sq_nxt[1][j] = sv_r[1][j] * sv_r[1][j];
    end
    dot_nxt = DotW'(dp_r[0]) + DotW'(dp_r[1]) + DotW'(dp_r[2]);
    nn_nxt  = sq_r[0][0] + sq_r[0][1] + sq_r[0][2];
    cc_nxt  = sq_r[1][0] + sq_r[1][1] + sq_r[1][2];
  end

  always_comb begin
    ctl_nxt[0] = ctl_i;
    for (int s = 1; s < NStg; s++) begin
      ctl_nxt[s] = ctl_r[s-1];
    end
    ctl_nxt[DegStg].degen = degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NStg; s++) ctl_r[s] <= '0;
    end else if (en) begin
      for (int s = 0; s < NStg; s++) ctl_r[s] <= ctl_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r    <= xp_nxt;
      c4_r    <= c_i;
      c5_r    <= c4_r;
      n_r     <= n_nxt;
      mag_r   <= mag_nxt;
      sgn_r   <= sgn_nxt;
      mag7_r  <= mag_r;
      sgn7_r  <= sgn_r;
      right_r <= right_nxt;
      amt_r   <= amt_nxt;
      sv_r    <= sv_nxt;
      dp_r    <= dp_nxt;
      sq_r    <= sq_nxt;
      dot_r   <= dot_nxt;
      nn_r    <= nn_nxt;
      cc_r    <= cc_nxt;
    end
  end

  assign ctl_o = ctl_r[NStg-1];
  assign dot_o = dot_r;
  assign nn_o  = nn_r;
  assign cc_o  = cc_r;
endmodule

@@ rtl/core/fvac_isqrt.sv @@
`timescale 1ns / 1ps
module fvac_isqrt #(
  parameter int RootW = fvac_pkg::RootW,
  parameter int Lanes = 2,
  parameter int SideW = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              v_i,
  input  logic [SideW-1:0]                  side_i,
  input  logic [Lanes-1:0][2*RootW-1:0]     rad_i,
  output logic                              v_o,
  output logic [SideW-1:0]                  side_o,
  output logic [Lanes-1:0][RootW-1:0]       root_o
);
  localparam int StepsPer = 2;
  localparam int NStage   = (RootW + StepsPer - 1) / StepsPer;
  localparam int TotSteps = NStage * StepsPer;
  localparam int PadW     = 2 * TotSteps;
  localparam int RemW     = TotSteps + 3;

  logic [RemW-1:0]     rem_r [NStage][Lanes];
  logic [RemW-1:0]     rem_nxt [NStage][Lanes];
  logic [TotSteps-1:0] root_r [NStage][Lanes];
  logic [TotSteps-1:0] root_nxt [NStage][Lanes];
  logic [PadW-1:0]     rad_r [NStage][Lanes];
  logic [PadW-1:0]     rad_nxt [NStage][Lanes];
  logic [SideW-1:0]    side_r [NStage];
  logic [NStage-1:0]   v_r, v_nxt;

  // Two result bits per stage: shift in a digit pair, try (root<<2)|1.
  always_comb begin
    logic [RemW-1:0]     rm;
    logic [RemW-1:0]     trial;
    logic [TotSteps-1:0] rt;
    logic [PadW-1:0]     rd;
    int                  t;
    for (int s = 0; s < NStage; s++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (s == 0) begin
          rm = '0;
          rt = '0;
          rd = PadW'(rad_i[l]);
        end else begin
          rm = rem_r[(s == 0) ? 0 : s - 1][l];
          rt = root_r[(s == 0) ? 0 : s - 1][l];
          rd = rad_r[(s == 0) ? 0 : s - 1][l];
        end
        for (int u = 0; u < StepsPer; u++) begin
          t     = s * StepsPer + u;
          rm    = {rm[RemW-3:0], rd[PadW-1-2*t -: 2]};
          trial = RemW'({rt, 2'b01});
          if (rm >= trial) begin
            rm = rm - trial;
            rt = {rt[TotSteps-2:0], 1'b1};
          end else begin
            rt = {rt[TotSteps-2:0], 1'b0};
          end
        end
        rem_nxt[s][l]  = rm;
        root_nxt[s][l] = rt;
        rad_nxt[s][l]  = rd;
      end
    end
  end

  assign v_nxt = {v_r[NStage-2:0], v_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      side_r[0] <= side_i;
      for (int s = 1; s < NStage; s++) side_r[s] <= side_r[s-1];
    end
  end

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      root_o[l] = root_r[NStage-1][l][RootW-1:0];
    end
  end

  assign v_o    = v_r[NStage-1];
  assign side_o = side_r[NStage-1];
endmodule

@@ rtl/core/fvac_div.sv @@
`timescale 1ns / 1ps
module fvac_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  fvac_pkg::ctl_t                      ctl_i,
  input  logic signed [fvac_pkg::DotW-1:0]    dot_i,
  input  logic [1:0][fvac_pkg::RootW-1:0]     len_i,
  input  logic signed [fvac_pkg::ThrW-1:0]    thr,
  output logic                                valid_o,
  output logic signed [fvac_pkg::CosW-1:0]    cosine_o,
  output logic                                below_o,
  output logic                                degen_o
);
  localparam int DotW     = fvac_pkg::DotW;
  localparam int MagW     = fvac_pkg::MagW;
  localparam int DenW     = fvac_pkg::DenW;
  localparam int NumW     = fvac_pkg::NumW;
  localparam int NumShift = fvac_pkg::NumShift;
  localparam int QW       = fvac_pkg::QW;
  localparam int CosW     = fvac_pkg::CosW;

  fvac_pkg::ctl_t      ctl_a_r, ctl_b_r;
  logic [DenW-1:0]     den_a_r, den_a_nxt;
  logic [MagW-1:0]     mag_a_r, mag_a_nxt;
  logic                neg_a_r;
  logic [NumW-1:0]     num_b_r, num_b_nxt;
  logic [DenW-1:0]     den_b_r;
  logic                neg_b_r, ovf_b_r, ovf_b_nxt;

  fvac_pkg::ctl_t      ctl_r [QW];
  logic [NumW-1:0]     rem_r [QW];
  logic [NumW-1:0]     rem_nxt [QW];
  logic [QW-1:0]       q_r [QW];
  logic [QW-1:0]       q_nxt [QW];
  logic [DenW-1:0]     den_r [QW];
  logic [QW-1:0]       neg_r, ovf_r;

  logic                out_v_r;
  logic [CosW-1:0]     cos_r, cos_nxt;
  logic                below_r, below_nxt, degen_r;

  always_comb begin
    den_a_nxt = len_i[0] * len_i[1];
    mag_a_nxt = dot_i[DotW-1] ? MagW'(-dot_i) : MagW'(dot_i);
  end

  // Rounded quotient: (|dot| << 30 + den/2) / den; saturate at 2^QW.
  always_comb begin
    num_b_nxt = (NumW'(mag_a_r) << NumShift) + NumW'(den_a_r >> 1);
    ovf_b_nxt = (num_b_nxt >= (NumW'(den_a_r) << QW));
  end

  // Restoring division, one quotient bit a stage from the top.
  always_comb begin
    logic [NumW-1:0] rm;
    logic [QW-1:0]   qq;
    logic [DenW-1:0] dd;
    for (int d = 0; d < QW; d++) begin
      if (d == 0) begin
        rm = num_b_r;
        qq = '0;
        dd = den_b_r;
      end else begin
        rm = rem_r[(d == 0) ? 0 : d - 1];
        qq = q_r[(d == 0) ? 0 : d - 1];
        dd = den_r[(d == 0) ? 0 : d - 1];
      end
      if (rm >= (NumW'(dd) << (QW - 1 - d))) begin
        rm = rm - (NumW'(dd) << (QW - 1 - d));
        qq[QW-1-d] = 1'b1;
      end
      rem_nxt[d] = rm;
      q_nxt[d]   = qq;
    end
  end

  // Clamp to one, apply sign, compare against the threshold.
  // A degenerate word carries a zero cosine and a clear flag.
  always_comb begin
    logic [CosW-1:0] qc;
    qc = CosW'(q_r[QW-1]);
    if (ovf_r[QW-1] || (qc > fvac_pkg::CosOne)) qc = fvac_pkg::CosOne;
    cos_nxt = neg_r[QW-1] ? (~qc + 1'b1) : qc;
    if (ctl_r[QW-1].degen) cos_nxt = '0;
    below_nxt = !ctl_r[QW-1].degen && ($signed(cos_nxt) < thr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
      for (int d = 0; d < QW; d++) ctl_r[d] <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      ctl_a_r  <= ctl_i;
      ctl_b_r  <= ctl_a_r;
      ctl_r[0] <= ctl_b_r;
      for (int d = 1; d < QW; d++) ctl_r[d] <= ctl_r[d-1];
      out_v_r  <= ctl_r[QW-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_a_r  <= den_a_nxt;
      mag_a_r  <= mag_a_nxt;
      neg_a_r  <= dot_i[DotW-1];
      num_b_r  <= num_b_nxt;
      den_b_r  <= den_a_r;
      neg_b_r  <= neg_a_r;
      ovf_b_r  <= ovf_b_nxt;
      rem_r    <= rem_nxt;
      q_r      <= q_nxt;
      den_r[0] <= den_b_r;
      for (int d = 1; d < QW; d++) den_r[d] <= den_r[d-1];
      neg_r    <= {neg_r[QW-2:0], neg_b_r};
      ovf_r    <= {ovf_r[QW-2:0], ovf_b_r};
      cos_r    <= cos_nxt;
      below_r  <= below_nxt;
      degen_r  <= ctl_r[QW-1].degen;
    end
  end

  assign valid_o  = out_v_r;
  assign cosine_o = $signed(cos_r);
  assign below_o  = below_r;
  assign degen_o  = degen_r;
endmodule

@@ rtl/core/face_view_angle_cosine_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake        | Word
// in_ch    | in        | valid / ready    | triangle a_x..c_z, Q8.8
// out_ch   | out       | valid / ready    | cosine Q1.14, below_threshold, degenerate
// APB      | in        | psel/penable     | matrix rows (64b) and threshold, 8-byte stride
//
// The pipe runs transform, cross/normalize, square root (two root bits a stage),
// then product, divide (one quotient bit a stage) and output.
// One word enters per clock unless the output stalls; the whole pipe moves on a single enable.
// rst_n is synchronous and clears every valid bit and the configuration registers.
// A stalled output word freezes the pipe; in_ch.ready drops only then.
module face_view_angle_cosine_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  fvac_in_if.sink                      in_ch,
  fvac_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fvac_pkg::AddrW-1:0]   paddr,
  input  logic [fvac_pkg::DataW-1:0]   pwdata,
  output logic [fvac_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  localparam int EW       = fvac_pkg::EW;
  localparam int DotW     = fvac_pkg::DotW;
  localparam int SqW      = fvac_pkg::SqW;
  localparam int RootW    = fvac_pkg::RootW;
  localparam int RadShift = fvac_pkg::RadShift;
  localparam int CoordW   = fvac_pkg::CoordW;
  localparam int SideW    = DotW + 1;

  fvac_pkg::cfg_t cfg;
  fvac_pkg::ctl_t ctl_x, ctl_n, ctl_s;
  logic           en;
  logic           out_valid;

  logic [2:0][2:0][CoordW-1:0] vtx;
  logic [2:0][EW-1:0]          e1, e2, cen;
  logic signed [DotW-1:0]      dot_n, dot_s;
  logic [SqW-1:0]              nn, cc;
  logic [1:0][2*RootW-1:0]     rad;
  logic [1:0][RootW-1:0]       len;
  logic [SideW-1:0]            side_s;
  logic                        v_s;

  // Advance the whole pipe unless the output word is held.
  assign en          = ~out_valid | out_ch.ready;
  assign in_ch.ready = en;

  assign vtx[0] = {in_ch.a_z, in_ch.a_y, in_ch.a_x};
  assign vtx[1] = {in_ch.b_z, in_ch.b_y, in_ch.b_x};
  assign vtx[2] = {in_ch.c_z, in_ch.c_y, in_ch.c_x};

  fvac_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fvac_xform u_xform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .vtx      (vtx),
    .cfg      (cfg),
    .ctl_o    (ctl_x),
    .e1_o     (e1),
    .e2_o     (e2),
    .c_o      (cen)
  );

  fvac_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl_x),
    .e1_i  (e1),
    .e2_i  (e2),
    .c_i   (cen),
    .ctl_o (ctl_n),
    .dot_o (dot_n),
    .nn_o  (nn),
    .cc_o  (cc)
  );

  // Squared lengths scaled by 2^16 before the root.
  assign rad[0] = {nn, {RadShift{1'b0}}};
  assign rad[1] = {cc, {RadShift{1'b0}}};

  fvac_isqrt #(
    .RootW (RootW),
    .Lanes (2),
    .SideW (SideW)
  ) u_isqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (ctl_n.valid),
    .side_i ({ctl_n.degen, dot_n}),
    .rad_i  (rad),
    .v_o    (v_s),
    .side_o (side_s),
    .root_o (len)
  );

  assign ctl_s.valid = v_s;
  assign ctl_s.degen = side_s[SideW-1];
  assign dot_s       = $signed(side_s[DotW-1:0]);

  fvac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_i    (ctl_s),
    .dot_i    (dot_s),
    .len_i    (len),
    .thr      (cfg.thr),
    .valid_o  (out_valid),
    .cosine_o (out_ch.cosine),
    .below_o  (out_ch.below_threshold),
    .degen_o  (out_ch.degenerate)
  );

  assign out_ch.valid = out_valid;
endmodule

@@ rtl/core/fvac_checker.sv @@
`timescale 1ns / 1ps
`include "face_view_angle_cosine_unit_defines.svh"
module fvac_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [fvac_pkg::CosW-1:0]   cosine,
  input logic                               below_threshold,
  input logic                               degenerate
);
  `FVAC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(cosine) && $stable(below_threshold) && $stable(degenerate),
    "stalled output word changed")
  `FVAC_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid && degenerate,
    (cosine == '0) && !below_threshold, "degenerate word carries a cosine or flag")
  `FVAC_ASSERT_IMP(a_cos_range, clk, rst_n, out_valid,
    (cosine >= -16'sd16384) && (cosine <= 16'sd16384), "cosine outside unit range")
  `FVAC_ASSERT_IMP(a_ready_stall, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready),
    "input ready does not follow the output stall")
  `FVAC_ASSERT_RST(a_reset_empty, clk, !rst_n, !out_valid, "output valid after reset")
endmodule

bind face_view_angle_cosine_unit fvac_checker u_fvac_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .cosine          (out_ch.cosine),
  .below_threshold (out_ch.below_threshold),
  .degenerate      (out_ch.degenerate)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  typedef logic signed [fvac_pkg::CoordW-1:0] face_t [9];

  typedef struct {
    logic signed [fvac_pkg::CosW-1:0] cosine;
    logic                             below;
    logic                             degen;
  } view_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel, penable, pwrite, pready;
  logic [fvac_pkg::AddrW-1:0] paddr;
  logic [fvac_pkg::DataW-1:0] pwdata, prdata;

  fvac_in_if  in_ch ();
  fvac_out_if out_ch ();

  face_view_angle_cosine_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // Shadow copy of the block's registers, updated as each write lands.
  logic [fvac_pkg::DataW-1:0]       shadow_row [3];
  logic signed [fvac_pkg::ThrW-1:0] shadow_thr;

  view_res_t pending_views [$];
  int n_faces, n_checked, n_degen, n_below, n_errors, n_cfg;

  // Sender pacing: words left in the current burst, and whether gaps are on.
  int  burst_left;
  bit  gaps_on;
  int  stall_mode;

  // ---------------------------------------------------------------------------
  // Face predictor
  // ---------------------------------------------------------------------------

  // Affine row in Q8.8: floor of the Q4.12 weighted sum plus translation.
  function automatic longint apply_row(logic [fvac_pkg::DataW-1:0] w, longint x,
                                       longint y, longint z);
    longint acc;
    acc = longint'($signed(w[15:0])) * x + longint'($signed(w[31:16])) * y
        + longint'($signed(w[47:32])) * z + longint'($signed(w[63:48])) * 4096;
    return acc >>> fvac_pkg::FracShift;
  endfunction

  // Bring the largest magnitude into [2^14, 2^15); right shifts truncate
  // toward zero, left shifts are exact.
  function automatic void fit_vec(inout longint v[3]);
    longint m, a;
    int s, k;
    m = 0;
    s = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? -v[i] : v[i];
      if (a > m) m = a;
    end
    while ((m >> s) >= 32768) s++;
    while ((m << k) < 16384) k++;
    for (int i = 0; i < 3; i++) begin
      a = (v[i] < 0) ? -v[i] : v[i];
      if (s > 0) v[i] = (v[i] < 0) ? -(a >> s) : (a >> s);
      else v[i] = v[i] << k;
    end
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic view_res_t predict_view(face_t f);
    longint p[3][3];
    longint e1[3], e2[3], nrm[3], cen[3];
    longint dot, cosv;
    longint unsigned nn, cc, den, num, q;
    view_res_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = apply_row(shadow_row[j], f[3*i], f[3*i+1], f[3*i+2]);
    for (int j = 0; j < 3; j++) begin
      e1[j]  = p[1][j] - p[0][j];
      e2[j]  = p[2][j] - p[0][j];
      cen[j] = p[0][j] + p[1][j] + p[2][j];
    end
    nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.cosine = '0;
    r.below  = 1'b0;
    r.degen  = 1'b0;
    // Zero normal or zero centroid: no direction, report degenerate.
    if ((nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0) ||
        (cen[0] == 0 && cen[1] == 0 && cen[2] == 0)) begin
      r.degen = 1'b1;
      return r;
    end
    fit_vec(nrm);
    fit_vec(cen);
    dot = nrm[0] * cen[0] + nrm[1] * cen[1] + nrm[2] * cen[2];
    nn  = nrm[0] * nrm[0] + nrm[1] * nrm[1] + nrm[2] * nrm[2];
    cc  = cen[0] * cen[0] + cen[1] * cen[1] + cen[2] * cen[2];
    den = floor_sqrt(nn << fvac_pkg::RadShift) * floor_sqrt(cc << fvac_pkg::RadShift);
    num = longint'((dot < 0) ? -dot : dot) << fvac_pkg::NumShift;
    q   = (num + den / 2) / den;
    if (q > 16384) q = 16384;
    cosv = (dot < 0) ? -longint'(q) : longint'(q);
    r.cosine = cosv[fvac_pkg::CosW-1:0];
    r.below  = cosv < longint'(shadow_thr);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus and channel helpers
  // ---------------------------------------------------------------------------

  // Setup then access phase; the register lands at the access edge.
  task automatic write_reg(fvac_pkg::reg_idx_t idx, logic [fvac_pkg::DataW-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fvac_pkg::AddrW'(idx) << fvac_pkg::ByteSelW;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == fvac_pkg::REG_THRESH) shadow_thr = value[fvac_pkg::ThrW-1:0];
    else shadow_row[idx] = value;
    n_cfg++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [fvac_pkg::DataW-1:0] pack_row(int m0, int m1, int m2, int t);
    return {16'(t), 16'(m2), 16'(m1), 16'(m0)};
  endfunction

  task automatic load_matrix(logic [fvac_pkg::DataW-1:0] rx, logic [fvac_pkg::DataW-1:0] ry,
                             logic [fvac_pkg::DataW-1:0] rz,
                             logic signed [fvac_pkg::ThrW-1:0] thr);
    write_reg(fvac_pkg::REG_ROW_X, rx);
    write_reg(fvac_pkg::REG_ROW_Y, ry);
    write_reg(fvac_pkg::REG_ROW_Z, rz);
    write_reg(fvac_pkg::REG_THRESH, {{(fvac_pkg::DataW-fvac_pkg::ThrW){1'b0}}, thr});
  endtask

  // Wait for every expected word, then let the pipe run empty.
  task automatic drain;
    int guard;
    guard = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  // At the next falling edge, present one face on the input channel and hold
  // it until accepted. Gaps come between bursts.
  task automatic send_face(face_t f);
    @(negedge clk);
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_ch.a_x <= f[0]; in_ch.a_y <= f[1]; in_ch.a_z <= f[2];
    in_ch.b_x <= f[3]; in_ch.b_y <= f[4]; in_ch.b_z <= f[5];
    in_ch.c_x <= f[6]; in_ch.c_y <= f[7]; in_ch.c_z <= f[8];
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_views = {pending_views, predict_view(f)};
    n_faces++;
    if (burst_left > 0) burst_left--;
  endtask

  function automatic face_t rand_face(int span);
    face_t f;
    for (int i = 0; i < 9; i++) f[i] = 16'($urandom_range(0, 2 * span) - span);
    return f;
  endfunction

  function automatic face_t full_face();
    face_t f;
    for (int i = 0; i < 9; i++) f[i] = 16'($urandom());
    return f;
  endfunction

  // Mostly honest triangles; a few collapse to a line, or
  // have their centroid at the eye.
  function automatic face_t mixed_face(int span);
    face_t f;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      f = full_face();
    end else begin
      f = rand_face(span);
    end
    if (pick >= 90 && pick < 94) begin
      for (int i = 0; i < 3; i++) f[3+i] = f[i];
    end else if (pick >= 94 && pick < 97) begin
      for (int i = 0; i < 3; i++) f[6+i] = 16'(2 * int'(f[3+i]) - int'(f[i]));
    end else if (pick >= 97) begin
      for (int i = 0; i < 6; i++) f[i] = 16'($urandom_range(0, 2000) - 1000);
      for (int i = 0; i < 3; i++) f[6+i] = -(f[i] + f[3+i]);
    end
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    view_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_views.size() == 0) begin
        $display("%0t: unexpected word cosine=%0d below=%0b degenerate=%0b", $time,
                 out_ch.cosine, out_ch.below_threshold, out_ch.degenerate);
        n_errors++;
      end else begin
        want = pending_views.pop_front();
        n_checked++;
        if (want.degen) n_degen++;
        if (want.below) n_below++;
        if (out_ch.cosine !== want.cosine) begin
          $display("%0t: cosine expected %0d, got %0d", $time, want.cosine,
                   out_ch.cosine);
          n_errors++;
        end
        if (out_ch.below_threshold !== want.below) begin
          $display("%0t: below_threshold expected %0b, got %0b", $time, want.below,
                   out_ch.below_threshold);
          n_errors++;
        end
        if (out_ch.degenerate !== want.degen) begin
          $display("%0t: degenerate expected %0b, got %0b", $time, want.degen,
                   out_ch.degenerate);
          n_errors++;
        end
      end
    end
  end

  // Receiver back-pressure: switch between always ready, light stalls and
  // long stalls every so often.
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed;
    face_t f;
    logic [fvac_pkg::DataW-1:0] unit_x, unit_y, unit_z;
    unit_x = pack_row(4096, 0, 0, 0);
    unit_y = pack_row(0, 4096, 0, 0);
    unit_z = pack_row(0, 0, 4096, 0);
    load_matrix(unit_x, unit_y, unit_z, 16'sd0);
    gaps_on = 1'b0;
    // Face in the z = 256 plane, seen head on from both windings.
    f = '{0, 0, 256, 256, 0, 256, 0, 256, 256};
    send_face(f);
    f = '{0, 0, 256, 0, 256, 256, 256, 0, 256};
    send_face(f);
    // Edge-on: plane contains the eye ray.
    f = '{0, 0, 256, 0, 256, 256, 0, 0, 512};
    send_face(f);
    // Collapsed to a point, then to a line.
    f = '{300, -20, 7, 300, -20, 7, 300, -20, 7};
    send_face(f);
    f = '{0, 0, 0, 100, 100, 100, 200, 200, 200};
    send_face(f);
    // Centroid at the eye.
    f = '{100, 0, 0, 0, 100, 0, -100, -100, 0};
    send_face(f);
    // Field extremes.
    f = '{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768};
    send_face(f);
    f = '{-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767};
    send_face(f);
    f = '{32767, 0, 0, 0, 32767, 0, 0, 0, 32767};
    send_face(f);
    f = '{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768};
    send_face(f);
    f = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_face(f);
    f = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};
    send_face(f);
    drain();

    // Threshold at both ends of its range, and beyond.
    load_matrix(unit_x, unit_y, unit_z, -16'sd16384);
    f = '{0, 0, 256, 0, 256, 256, 256, 0, 256};
    send_face(f);
    f = '{0, 0, 256, 256, 0, 256, 0, 256, 256};
    send_face(f);
    drain();
    write_reg(fvac_pkg::REG_THRESH, 64'd16384);
    send_face(f);
    f = '{0, 0, 256, 0, 256, 256, 256, 0, 256};
    send_face(f);
    drain();
    write_reg(fvac_pkg::REG_THRESH, 64'h8000);
    send_face(f);
    drain();
    write_reg(fvac_pkg::REG_THRESH, 64'h7FFF);
    send_face(f);
    drain();

    // Matrix at its extremes: largest coefficients and translations.
    load_matrix(pack_row(32767, 32767, 32767, 32767),
                pack_row(-32768, -32768, -32768, -32768),
                pack_row(32767, -32768, 32767, -32768), 16'sd0);
    f = '{32767, -32768, 32767, -32768, 32767, -32768, 100, 200, -300};
    send_face(f);
    f = '{10, 20, 30, -40, 50, -60, 70, -80, 90};
    send_face(f);
    drain();
    // All-zero matrix: every vertex maps to the eye.
    load_matrix('0, '0, '0, 16'sd0);
    send_face(f);
    drain();
  endtask

  task automatic test_random_phase(int n_items, int span, bit wild);
    logic [fvac_pkg::DataW-1:0] rx, ry, rz;
    if (wild) begin
      rx = {$urandom(), $urandom()};
      ry = {$urandom(), $urandom()};
      rz = {$urandom(), $urandom()};
    end else begin
      // Near-orthonormal scale with random translation keeps cosines spread.
      rx = pack_row($urandom_range(2048, 8192), $urandom_range(0, 2000) - 1000,
                    $urandom_range(0, 2000) - 1000, $urandom_range(0, 20000) - 10000);
      ry = pack_row($urandom_range(0, 2000) - 1000, $urandom_range(2048, 8192),
                    $urandom_range(0, 2000) - 1000, $urandom_range(0, 20000) - 10000);
      rz = pack_row($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                    $urandom_range(2048, 8192), $urandom_range(0, 20000) - 10000);
    end
    load_matrix(rx, ry, rz, 16'($urandom_range(0, 32768) - 16384));
    gaps_on = $urandom_range(0, 3) != 0;
    burst_left = 0;
    for (int i = 0; i < n_items; i++) send_face(mixed_face(span));
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
    in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
    in_ch.c_x = '0; in_ch.c_y = '0; in_ch.c_z = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    stall_mode = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    n_faces = 0; n_checked = 0; n_degen = 0; n_below = 0; n_errors = 0; n_cfg = 0;
    for (int i = 0; i < 3; i++) shadow_row[i] = '0;
    shadow_thr = '0;

    // Hold reset, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(106, 4000, 1'b0);
    test_random_phase(106, 32767, 1'b0);
    test_random_phase(106, 500, 1'b0);
    test_random_phase(106, 32767, 1'b1);
    test_random_phase(106, 2000, 1'b1);

    $display("Covered %0d faces (%0d degenerate, %0d below threshold) over %0d writes.",
             n_checked, n_degen, n_below, n_cfg);
    if (n_errors == 0 && pending_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words outstanding", n_errors, pending_views.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #20_000_000;
    $display("Timeout with %0d words outstanding", pending_views.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ face_view_angle_cosine_unit.f @@
+incdir+rtl/core
rtl/core/fvac_pkg.sv
rtl/core/fvac_if.sv
rtl/core/fvac_regs.sv
rtl/core/fvac_xform.sv
rtl/core/fvac_norm.sv
rtl/core/fvac_isqrt.sv
rtl/core/fvac_div.sv
rtl/core/face_view_angle_cosine_unit.sv
rtl/core/fvac_checker.sv
dv/tb_top.sv
